// ===== design/rhht_pkg.sv =====
// Package: shared types and constants for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned OP_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;
endpackage
`default_nettype wire

// ===== design/rhht_if.sv =====
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface rhht_req_if;
  logic                      valid;
  logic                      ready;
  logic [rhht_pkg::OP_W-1:0] opcode;
  logic signed [63:0]        key;
  logic signed [63:0]        value;
  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

interface rhht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rhht_pkg::STATUS_W-1:0] status;
  logic signed [63:0]            found_value;
  logic [rhht_pkg::COUNT_W-1:0]  entry_count;
  modport source (output valid, output status, output found_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input found_value, input entry_count,
                output ready);
endinterface
`default_nettype wire

// ===== design/rhht_store.sv =====
// Slot store: key, value and occupancy memories with registered read.
`default_nettype none
module rhht_store (
  input  wire logic                      clk,
  input  wire logic [rhht_pkg::IDX_W-1:0] rd_idx,
  output logic [63:0]                    rd_key,
  output logic [63:0]                    rd_val,
  output logic                           rd_occ,
  input  wire logic                      wr_en,
  input  wire logic [rhht_pkg::IDX_W-1:0] wr_idx,
  input  wire logic [63:0]               wr_key,
  input  wire logic [63:0]               wr_val,
  input  wire logic                      occ_set,
  input  wire logic                      occ_clr,
  input  wire logic [rhht_pkg::IDX_W-1:0] occ_idx
);
  import rhht_pkg::*;

  logic [63:0] key_mem [CAPACITY];
  logic [63:0] val_mem [CAPACITY];
  logic        occ_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= wr_key;
      val_mem[wr_idx] <= wr_val;
    end
    if (occ_set) begin
      occ_mem[occ_idx] <= 1'b1;
    end else if (occ_clr) begin
      occ_mem[occ_idx] <= 1'b0;
    end
    rd_key <= key_mem[rd_idx];
    rd_val <= val_mem[rd_idx];
    rd_occ <= occ_mem[rd_idx];
  end
endmodule
`default_nettype wire

// ===== design/rhht_ctrl.sv =====
// Sequencer: probes, displaces and back-shifts one slot at a time.
`default_nettype none
module rhht_ctrl (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rhht_req_if.sink    req,
  rhht_rsp_if.source  rsp,
  output logic [rhht_pkg::IDX_W-1:0] rd_idx,
  input  wire logic [63:0]           rd_key,
  input  wire logic [63:0]           rd_val,
  input  wire logic                  rd_occ,
  output logic                       wr_en,
  output logic [rhht_pkg::IDX_W-1:0] wr_idx,
  output logic [63:0]                wr_key,
  output logic [63:0]                wr_val,
  output logic                       occ_set,
  output logic                       occ_clr,
  output logic [rhht_pkg::IDX_W-1:0] occ_idx
);
  import rhht_pkg::*;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FRD   = 9'b000000100,
    S_FCHK  = 9'b000001000,
    S_PRD   = 9'b000010000,
    S_PCHK  = 9'b000100000,
    S_DRD   = 9'b001000000,
    S_DCHK  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [63:0]      key_r, key_nxt, val_r, val_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] dist_r, dist_nxt, steps_r, steps_nxt, count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [63:0]      found_r, found_nxt;

  logic [IDX_W-1:0] home_in, home_rd, idx_inc, res_dist;
  logic [63:0]      hk_in, hk_rd;

  always_comb begin
    hk_in = req.key | 64'(req.key == 64'sd0);
    hk_rd = rd_key | 64'(rd_key == 64'd0);
    home_in = IDX_W'(hk_in % CAPACITY);
    home_rd = IDX_W'(hk_rd % CAPACITY);
    idx_inc = (idx_r == IDX_W'(CAPACITY - 1)) ? '0 : idx_r + 1'b1;
    res_dist = (idx_r >= home_rd) ? idx_r - home_rd
                                  : IDX_W'(CAPACITY - 32'(home_rd) + 32'(idx_r));
  end

  assign req.ready = (state_r == S_IDLE);
  assign rsp.valid = (state_r == S_OUT);
  assign rsp.status = status_r;
  assign rsp.found_value = found_r;
  assign rsp.entry_count = COUNT_W'(count_r);
  assign rd_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    key_nxt = key_r;
    val_nxt = val_r;
    idx_nxt = idx_r;
    dist_nxt = dist_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    status_nxt = status_r;
    found_nxt = found_r;
    wr_en = 1'b0;
    wr_idx = idx_r;
    wr_key = key_r;
    wr_val = val_r;
    occ_set = 1'b0;
    occ_clr = 1'b0;
    occ_idx = idx_r;
    unique case (state_r)
      S_CLR: begin
        occ_clr = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == IDX_W'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          op_nxt = req.opcode;
          key_nxt = req.key;
          val_nxt = req.value;
          idx_nxt = home_in;
          dist_nxt = '0;
          status_nxt = ST_MISSING;
          found_nxt = '0;
          if (req.opcode == OP_NOP || count_r == '0) begin
            if (req.opcode == OP_INSERT) begin
              state_nxt = S_PRD;
              steps_nxt = '0;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (!rd_occ || (rd_key != key_r && dist_r > CNT_W'(res_dist))
            || dist_r == CAP_C) begin
          if (op_r == OP_INSERT) begin
            if (count_r >= CAP_C) begin
              status_nxt = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              idx_nxt = IDX_W'(((key_r | 64'(key_r == 64'd0))) % CAPACITY);
              dist_nxt = '0;
              steps_nxt = '0;
              state_nxt = S_PRD;
            end
          end else begin
            state_nxt = S_OUT;
          end
        end else if (rd_key == key_r) begin
          status_nxt = ST_FOUND;
          unique case (op_r)
            OP_INSERT: begin
              wr_en = 1'b1;
              wr_key = rd_key;
              wr_val = val_r;
              state_nxt = S_OUT;
            end
            OP_DELETE: begin
              found_nxt = rd_val;
              count_nxt = count_r - 1'b1;
              steps_nxt = '0;
              idx_nxt = idx_inc;
              state_nxt = S_DRD;
              dist_nxt = CNT_W'(idx_r);
            end
            default: begin
              found_nxt = rd_val;
              state_nxt = S_OUT;
            end
          endcase
        end else begin
          idx_nxt = idx_inc;
          dist_nxt = dist_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (!rd_occ) begin
          wr_en = 1'b1;
          occ_set = 1'b1;
          count_nxt = count_r + 1'b1;
          status_nxt = ST_INSERTED;
          state_nxt = S_OUT;
        end else begin
          if (dist_r > CNT_W'(res_dist)) begin
            wr_en = 1'b1;
            key_nxt = rd_key;
            val_nxt = rd_val;
            dist_nxt = CNT_W'(res_dist) + 1'b1;
          end else begin
            dist_nxt = dist_r + 1'b1;
          end
          idx_nxt = idx_inc;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_DRD: state_nxt = S_DCHK;
      S_DCHK: begin
        // dist_r holds the hole index; idx_r the candidate after it.
        if (steps_r == CAP_C || !rd_occ || res_dist == '0) begin
          occ_clr = 1'b1;
          occ_idx = IDX_W'(dist_r);
          state_nxt = S_OUT;
        end else begin
          wr_en = 1'b1;
          wr_idx = IDX_W'(dist_r);
          wr_key = rd_key;
          wr_val = rd_val;
          dist_nxt = CNT_W'(idx_r);
          idx_nxt = idx_inc;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_OUT: begin
        if (rsp.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      count_r <= '0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
    end
    op_r <= op_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    dist_r <= dist_nxt;
    steps_r <= steps_nxt;
    status_r <= status_nxt;
    found_r <= found_nxt;
  end
endmodule
`default_nettype wire

// ===== design/robin_hood_hash_table.sv =====
// Top level: Robin Hood open-addressing key/value table.
// One request at a time: in_ready is high only in the idle state, and each request
// walks the table one slot at a time through a single registered-read port
// (address, then compare). Each request passes through the idle state, the probes
// and an output state that holds until out_ready is high. A new key also walks the
// slots of placement, displaced entries included; a delete also examines the slots
// that follow for the backward shift. A no-op, or any request on an empty table,
// skips the search. After reset the occupancy memory is cleared one slot per cycle,
// all CAPACITY (1024) slots, before in_ready first rises.
`default_nettype none
module robin_hood_hash_table (
  input wire logic   clk,
  input wire logic   rst_n,
  rhht_req_if.sink   in_req,
  rhht_rsp_if.source out_rsp
);
  import rhht_pkg::*;

  logic [IDX_W-1:0] rd_idx, wr_idx, occ_idx;
  logic [63:0] rd_key, rd_val, wr_key, wr_val;
  logic rd_occ, wr_en, occ_set, occ_clr;

  rhht_store u_store (
    .clk, .rd_idx, .rd_key, .rd_val, .rd_occ,
    .wr_en, .wr_idx, .wr_key, .wr_val, .occ_set, .occ_clr, .occ_idx
  );

  rhht_ctrl u_ctrl (
    .clk, .rst_n, .req(in_req), .rsp(out_rsp),
    .rd_idx, .rd_key, .rd_val, .rd_occ,
    .wr_en, .wr_idx, .wr_key, .wr_val, .occ_set, .occ_clr, .occ_idx
  );
endmodule
`default_nettype wire

// ===== test/tb_robin_hood_hash_table.sv =====
// Testbench: random and directed request checking for the Robin Hood hash table.
`timescale 1ns / 1ps
module tb_robin_hood_hash_table;
  import rhht_pkg::*;

  localparam int unsigned SLOTS = CAPACITY;

  typedef struct {
    status_t     st;
    logic [63:0] fv;
    logic [10:0] cnt;
  } reply_t;

  logic clk;
  logic rst_n;

  rhht_req_if in_req();
  rhht_rsp_if out_rsp();

  robin_hood_hash_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  logic [63:0] slot_key[SLOTS];
  logic [63:0] slot_val[SLOTS];
  bit          slot_used[SLOTS];
  int unsigned live_count;

  reply_t      pending_replies[$];
  logic [63:0] known_keys[$];
  int          err_cnt;
  int          hold_cycles;
  int          rdy_gap;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("robin_hood_hash_table verification failed");
    $finish;
  end

  function automatic int unsigned home_of(logic [63:0] k);
    logic [63:0] h;
    h = k | {63'd0, (k == 64'd0)};
    return 32'(h % SLOTS);
  endfunction

  function automatic int unsigned dist_at(int unsigned i);
    return (i + SLOTS - home_of(slot_key[i])) % SLOTS;
  endfunction

  function automatic int locate(logic [63:0] k);
    int unsigned i;
    i = home_of(k);
    if (live_count == 0) return -1;
    for (int unsigned d = 0; d < SLOTS; d++) begin
      if (!slot_used[i]) return -1;
      if (slot_key[i] == k) return i;
      if (d > dist_at(i)) return -1;
      i = (i + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic void place_entry(logic [63:0] k, logic [63:0] v);
    int unsigned i;
    int unsigned d;
    int unsigned di;
    logic [63:0] tk;
    logic [63:0] tv;
    i = home_of(k);
    d = 0;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_key[i] = k;
        slot_val[i] = v;
        return;
      end
      di = dist_at(i);
      if (d > di) begin
        tk = slot_key[i];
        tv = slot_val[i];
        slot_key[i] = k;
        slot_val[i] = v;
        k = tk;
        v = tv;
        d = di;
      end
      i = (i + 1) % SLOTS;
      d++;
    end
  endfunction

  function automatic void shift_back(int unsigned j);
    int unsigned n;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      n = (j + 1) % SLOTS;
      if (!slot_used[n] || dist_at(n) == 0) break;
      slot_key[j] = slot_key[n];
      slot_val[j] = slot_val[n];
      j = n;
    end
    slot_used[j] = 1'b0;
  endfunction

  function automatic reply_t apply_request(op_t op, logic [63:0] k, logic [63:0] v);
    reply_t r;
    int at;
    r.st = ST_MISSING;
    r.fv = '0;
    at = locate(k);
    case (op)
      OP_LOOKUP: begin
        if (at >= 0) begin
          r.st = ST_FOUND;
          r.fv = slot_val[at];
        end
      end
      OP_INSERT: begin
        if (at >= 0) begin
          slot_val[at] = v;
          r.st = ST_FOUND;
        end else if (live_count >= SLOTS) begin
          r.st = ST_FULL;
        end else begin
          place_entry(k, v);
          live_count++;
          r.st = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        if (at >= 0) begin
          r.fv = slot_val[at];
          shift_back(at);
          live_count--;
          r.st = ST_FOUND;
        end
      end
      default: ;
    endcase
    r.cnt = live_count[10:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(op_t op, logic [63:0] k, logic [63:0] v);
    int gap;
    @(negedge clk);
    in_req.valid  <= 1'b1;
    in_req.opcode <= op;
    in_req.key    <= k;
    in_req.value  <= v;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    pending_replies.push_back(apply_request(op, k, v));
    if (op == OP_INSERT) known_keys.push_back(k);
    gap = pick_gap();
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      if (i == 0) in_req.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] clustered_key();
    logic [63:0] k;
    k = rand_word();
    if ($urandom_range(0, 1)) k[9:0] = 10'(1020 + $urandom_range(0, 7));
    else k[9:0] = 10'($urandom_range(0, 15));
    return k;
  endfunction

  function automatic logic [63:0] pool_key();
    if (known_keys.size() == 0) return clustered_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_rsp.ready <= 1'b0;
      hold_cycles--;
    end else if (rdy_gap > 0) begin
      out_rsp.ready <= 1'b0;
      rdy_gap--;
    end else begin
      out_rsp.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0)
        rdy_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status %0d", out_rsp.status);
        err_cnt++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_rsp.status !== exp_r.st) begin
          $error("status: expected %0d actual %0d", exp_r.st, out_rsp.status);
          err_cnt++;
        end
        if (out_rsp.found_value !== exp_r.fv) begin
          $error("found_value: expected %h actual %h", exp_r.fv, out_rsp.found_value);
          err_cnt++;
        end
        if (out_rsp.entry_count !== exp_r.cnt) begin
          $error("entry_count: expected %0d actual %0d", exp_r.cnt, out_rsp.entry_count);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(OP_LOOKUP, 64'd5, '0);
    send_req(OP_DELETE, 64'd5, '0);
    send_req(OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(OP_INSERT, 64'd0, 64'h8000_0000_0000_0000);
    send_req(OP_INSERT, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_req(OP_LOOKUP, 64'd0, '0);
    send_req(OP_LOOKUP, 64'd1, '0);
    send_req(OP_INSERT, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    send_req(OP_INSERT, 64'd0, 64'd42);
    send_req(OP_LOOKUP, 64'd0, '0);
    send_req(OP_INSERT, 64'd5, 64'd50);
    send_req(OP_INSERT, 64'd1029, 64'd51);
    send_req(OP_INSERT, 64'd2053, 64'd52);
    send_req(OP_INSERT, 64'd6, 64'd60);
    send_req(OP_DELETE, 64'd5, '0);
    send_req(OP_LOOKUP, 64'd2053, '0);
    send_req(OP_LOOKUP, 64'd6, '0);
    send_req(OP_INSERT, 64'd1023, 64'd70);
    send_req(OP_INSERT, 64'd2047, 64'd71);
    send_req(OP_INSERT, 64'd3071, 64'd72);
    send_req(OP_DELETE, 64'd1023, '0);
    send_req(OP_LOOKUP, 64'd3071, '0);
    send_req(OP_DELETE, 64'd4095, '0);
    send_req(OP_NOP, 64'd1, '0);
    drain();
  endtask

  task automatic test_random_mix(int n);
    int r;
    op_t op;
    for (int i = 0; i < n; i++) begin
      if (i == n / 4) calm = 1'b1;
      if (i == n / 4 + 60) calm = 1'b0;
      if (i == n / 2) hold_cycles = 400;
      r = $urandom_range(0, 99);
      op = (r < 35) ? OP_INSERT : (r < 65) ? OP_LOOKUP : (r < 95) ? OP_DELETE : OP_NOP;
      send_req(op, ($urandom_range(0, 9) < 6) ? pool_key() : clustered_key(), rand_word());
    end
    drain();
  endtask

  task automatic test_fill_to_full();
    while (live_count < SLOTS) send_req(OP_INSERT, rand_word(), rand_word());
    for (int i = 0; i < 10; i++) send_req(OP_INSERT, clustered_key(), rand_word());
    for (int i = 0; i < 10; i++) send_req(OP_INSERT, pool_key(), rand_word());
    for (int i = 0; i < 20; i++)
      send_req(OP_LOOKUP, ($urandom_range(0, 1)) ? pool_key() : rand_word(), '0);
    drain();
  endtask

  task automatic test_drain_down();
    for (int i = 0; i < 150; i++)
      send_req(($urandom_range(0, 2) == 0) ? OP_LOOKUP : OP_DELETE, pool_key(), rand_word());
    drain();
  endtask

  initial begin
    err_cnt = 0;
    hold_cycles = 0;
    rdy_gap = 0;
    calm = 1'b0;
    live_count = 0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.opcode = OP_LOOKUP;
    in_req.key = '0;
    in_req.value = '0;
    out_rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix(540);
    test_fill_to_full();
    test_drain_down();

    repeat (40) @(posedge clk);
    if (err_cnt == 0 && pending_replies.size() == 0) begin
      $display("robin_hood_hash_table verification clean");
    end else begin
      $display("robin_hood_hash_table verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/rhht_pkg.sv
design/rhht_if.sv
design/rhht_store.sv
design/rhht_ctrl.sv
design/robin_hood_hash_table.sv
test/tb_robin_hood_hash_table.sv
